[src/crbg_pkg.sv]
`default_nettype none

package crbg_pkg;

    localparam int MAX_DIM    = 1024;
    localparam int DIM_W      = 11;
    localparam int BPP_W      = 3;
    localparam int POS_W      = 16;
    localparam int SIZE_W     = 15;
    localparam int OFF_W      = 20;
    localparam int CW         = 20;
    localparam int PROD_W     = 2 * DIM_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    localparam logic [BPP_W-1:0] PIXEL_BYTES = 3'd2;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_NEXT  = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DST_WIDTH,
        CFG_DST_HEIGHT,
        CFG_SRC_WIDTH,
        CFG_SRC_HEIGHT,
        CFG_DST_PIXEL_BYTES,
        CFG_SRC_PIXEL_BYTES,
        CFG_DST_BIG_ENDIAN,
        CFG_SRC_BIG_ENDIAN
    } t_cfg_idx;

    typedef logic [DIM_W-1:0]      t_dim;
    typedef logic signed [CW-1:0]  t_coord;

    typedef struct packed {
        logic                     cmd;
        logic signed [POS_W-1:0]  dst_x;
        logic signed [POS_W-1:0]  dst_y;
        logic signed [POS_W-1:0]  src_x;
        logic signed [POS_W-1:0]  src_y;
        logic [SIZE_W-1:0]        rect_width;
        logic [SIZE_W-1:0]        rect_height;
    } t_in_item;

    typedef struct packed {
        logic              row_valid;
        logic [OFF_W-1:0]  dst_offset;
        logic [OFF_W-1:0]  src_offset;
        logic [DIM_W-1:0]  pixel_count;
        logic              swap_bytes;
        logic              last_row;
        logic              copy_empty;
    } t_out_item;

    typedef struct packed {
        t_dim              dst_width;
        t_dim              dst_height;
        t_dim              src_width;
        t_dim              src_height;
        logic [BPP_W-1:0]  dst_pixel_bytes;
        logic [BPP_W-1:0]  src_pixel_bytes;
        logic              dst_big_endian;
        logic              src_big_endian;
    } t_cfg;

    typedef struct packed {
        t_dim dst_w;
        t_dim dst_h;
        t_dim src_w;
        t_dim src_h;
    } t_dims;

    // a is the side being clipped in a stage, b is the other side
    typedef struct packed {
        logic   cmd;
        t_coord ax;
        t_coord ay;
        t_coord bx;
        t_coord by;
        t_coord w;
        t_coord h;
    } t_clip;

    function automatic t_dim clamp_dim(input t_dim v);
        t_dim res;
        res = v;
        if (int'(v) > MAX_DIM) begin
            res = DIM_W'(MAX_DIM);
        end
        return res;
    endfunction

    function automatic t_coord to_coord(input t_dim v);
        return t_coord'({{(CW-DIM_W){1'b0}}, v});
    endfunction

endpackage

`default_nettype wire

[src/crbg_cfg.sv]
`default_nettype none

module crbg_cfg
    import crbg_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dst_width       <= DIM_W'(320);
            r_cfg.dst_height      <= DIM_W'(240);
            r_cfg.src_width       <= DIM_W'(320);
            r_cfg.src_height      <= DIM_W'(240);
            r_cfg.dst_pixel_bytes <= PIXEL_BYTES;
            r_cfg.src_pixel_bytes <= PIXEL_BYTES;
            r_cfg.dst_big_endian  <= 1'b0;
            r_cfg.src_big_endian  <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_DST_WIDTH:       r_cfg.dst_width       <= i_cfg_data[DIM_W-1:0];
                CFG_DST_HEIGHT:      r_cfg.dst_height      <= i_cfg_data[DIM_W-1:0];
                CFG_SRC_WIDTH:       r_cfg.src_width       <= i_cfg_data[DIM_W-1:0];
                CFG_SRC_HEIGHT:      r_cfg.src_height      <= i_cfg_data[DIM_W-1:0];
                CFG_DST_PIXEL_BYTES: r_cfg.dst_pixel_bytes <= i_cfg_data[BPP_W-1:0];
                CFG_SRC_PIXEL_BYTES: r_cfg.src_pixel_bytes <= i_cfg_data[BPP_W-1:0];
                CFG_DST_BIG_ENDIAN:  r_cfg.dst_big_endian  <= i_cfg_data[0];
                CFG_SRC_BIG_ENDIAN:  r_cfg.src_big_endian  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

[src/crbg_clip.sv]
`default_nettype none

module crbg_clip
    import crbg_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    output logic       o_ready,
    input  wire t_clip i_data,
    input  wire t_dim  i_lim_x,
    input  wire t_dim  i_lim_y,
    output logic       o_valid,
    input  wire logic  i_ready,
    output t_clip      o_data
);

    logic   r_valid;
    t_clip  r_data;
    t_clip  n_data;
    t_coord lim_x;
    t_coord lim_y;

    assign lim_x = to_coord(i_lim_x);
    assign lim_y = to_coord(i_lim_y);

    always_comb begin
        n_data = i_data;
        // clip left and top: shift both sides, shrink the size
        if (i_data.ax < 0) begin
            n_data.ax = '0;
            n_data.bx = i_data.bx - i_data.ax;
            n_data.w  = i_data.w + i_data.ax;
        end
        if (i_data.ay < 0) begin
            n_data.ay = '0;
            n_data.by = i_data.by - i_data.ay;
            n_data.h  = i_data.h + i_data.ay;
        end
        // clip right and bottom
        if (n_data.ax + n_data.w > lim_x) begin
            n_data.w = lim_x - n_data.ax;
        end
        if (n_data.ay + n_data.h > lim_y) begin
            n_data.h = lim_y - n_data.ay;
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

[src/crbg_row.sv]
`default_nettype none

module crbg_row
    import crbg_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    output logic       o_ready,
    input  wire t_clip i_data,
    input  wire t_cfg  i_cfg,
    input  wire t_dims i_dims,
    output logic       o_out_valid,
    input  wire logic  i_out_stall,
    output t_out_item  o_out
);

    logic             r_out_valid;
    t_out_item        r_out;
    t_out_item        n_out;

    logic             r_active;
    logic [OFF_W-1:0] r_dst_off;
    logic [OFF_W-1:0] r_src_off;
    t_dim             r_rows_left;
    t_dim             r_row_len;
    logic             r_swap;
    t_dim             r_dst_pitch;
    t_dim             r_src_pitch;

    logic             n_active;
    logic [OFF_W-1:0] n_dst_off;
    logic [OFF_W-1:0] n_src_off;
    t_dim             n_rows_left;
    t_dim             n_row_len;
    logic             n_swap;
    t_dim             n_dst_pitch;
    t_dim             n_src_pitch;

    t_coord           dx;
    t_coord           dy;
    t_coord           sx;
    t_coord           sy;
    logic             empty;
    logic [PROD_W-1:0] dst_prod;
    logic [PROD_W-1:0] src_prod;
    logic             fire;

    // after the source stage the destination sits on the b side
    assign dx = i_data.bx;
    assign dy = i_data.by;
    assign sx = i_data.ax;
    assign sy = i_data.ay;

    assign empty = (i_data.w <= 0) || (i_data.h <= 0)
                || (i_cfg.dst_pixel_bytes != PIXEL_BYTES)
                || (i_cfg.src_pixel_bytes != PIXEL_BYTES);

    assign dst_prod = PROD_W'(dy[DIM_W-1:0]) * PROD_W'(i_dims.dst_w);
    assign src_prod = PROD_W'(sy[DIM_W-1:0]) * PROD_W'(i_dims.src_w);

    always_comb begin
        n_out       = '0;
        n_active    = r_active;
        n_dst_off   = r_dst_off;
        n_src_off   = r_src_off;
        n_rows_left = r_rows_left;
        n_row_len   = r_row_len;
        n_swap      = r_swap;
        n_dst_pitch = r_dst_pitch;
        n_src_pitch = r_src_pitch;
        case (i_data.cmd)
            CMD_START: begin
                if (empty) begin
                    n_out.copy_empty = 1'b1;
                    n_active         = 1'b0;
                    n_rows_left      = '0;
                    n_row_len        = '0;
                end else begin
                    n_active    = 1'b1;
                    n_dst_pitch = i_dims.dst_w;
                    n_src_pitch = i_dims.src_w;
                    n_dst_off   = OFF_W'(dst_prod + PROD_W'(dx[DIM_W-1:0]));
                    n_src_off   = OFF_W'(src_prod + PROD_W'(sx[DIM_W-1:0]));
                    n_rows_left = i_data.h[DIM_W-1:0];
                    n_row_len   = i_data.w[DIM_W-1:0];
                    n_swap      = i_cfg.dst_big_endian ^ i_cfg.src_big_endian;
                end
            end
            CMD_NEXT: begin
                if (r_active && (r_rows_left != '0)) begin
                    n_out.row_valid   = 1'b1;
                    n_out.dst_offset  = r_dst_off;
                    n_out.src_offset  = r_src_off;
                    n_out.pixel_count = r_row_len;
                    n_out.swap_bytes  = r_swap;
                    n_out.last_row    = (r_rows_left == DIM_W'(1));
                    n_rows_left       = r_rows_left - DIM_W'(1);
                    n_dst_off         = r_dst_off + OFF_W'(r_dst_pitch);
                    n_src_off         = r_src_off + OFF_W'(r_src_pitch);
                    if (r_rows_left == DIM_W'(1)) begin
                        n_active = 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

    assign o_ready = !r_out_valid || !i_out_stall;
    assign fire    = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_active    <= 1'b0;
            r_dst_off   <= '0;
            r_src_off   <= '0;
            r_rows_left <= '0;
            r_row_len   <= '0;
            r_swap      <= 1'b0;
            r_dst_pitch <= '0;
            r_src_pitch <= '0;
        end else begin
            if (o_ready) begin
                r_out_valid <= i_valid;
            end
            if (fire) begin
                r_active    <= n_active;
                r_dst_off   <= n_dst_off;
                r_src_off   <= n_src_off;
                r_rows_left <= n_rows_left;
                r_row_len   <= n_row_len;
                r_swap      <= n_swap;
                r_dst_pitch <= n_dst_pitch;
                r_src_pitch <= n_src_pitch;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

[src/clipped_blit_row_generator.sv]
// channel   | direction | handshake                  | beat
// ----------+-----------+----------------------------+--------------------------
// in        | input     | i_in_valid / o_in_stall    | t_in_item command
// out       | output    | o_out_valid / i_out_stall  | t_out_item result
// cfg       | input     | i_cfg_we                   | i_cfg_index, i_cfg_data
//
// One command per cycle unless o_in_stall is high; each beat passes through:
// input register, destination clip stage, source clip stage, row stage
// (offset multiply and blit state). Synchronous active-low reset empties all
// stages and clears the blit state. A stall on the output holds the row stage;
// earlier stages keep filling empty slots before the input stalls.
`default_nettype none

module clipped_blit_row_generator
    import crbg_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire t_in_item              i_in,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output t_out_item                  o_out,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg     cfg;
    t_dims    dims;

    logic     r_in_valid;
    t_in_item r_in;
    logic     in_ready;

    t_clip    s0_data;
    logic     s1_ready;
    logic     s1_valid;
    t_clip    s1_data;
    t_clip    s1_swapped;
    logic     s2_ready;
    logic     s2_valid;
    t_clip    s2_data;
    logic     row_ready;

    crbg_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    assign dims.dst_w = clamp_dim(cfg.dst_width);
    assign dims.dst_h = clamp_dim(cfg.dst_height);
    assign dims.src_w = clamp_dim(cfg.src_width);
    assign dims.src_h = clamp_dim(cfg.src_height);

    assign in_ready   = !r_in_valid || s1_ready;
    assign o_in_stall = !in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_in_valid) begin
            r_in <= i_in;
        end
    end

    assign s0_data.cmd = r_in.cmd;
    assign s0_data.ax  = CW'(r_in.dst_x);
    assign s0_data.ay  = CW'(r_in.dst_y);
    assign s0_data.bx  = CW'(r_in.src_x);
    assign s0_data.by  = CW'(r_in.src_y);
    assign s0_data.w   = t_coord'({{(CW-SIZE_W){1'b0}}, r_in.rect_width});
    assign s0_data.h   = t_coord'({{(CW-SIZE_W){1'b0}}, r_in.rect_height});

    crbg_clip u_clip_dst (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_valid),
        .o_ready (s1_ready),
        .i_data  (s0_data),
        .i_lim_x (dims.dst_w),
        .i_lim_y (dims.dst_h),
        .o_valid (s1_valid),
        .i_ready (s2_ready),
        .o_data  (s1_data)
    );

    assign s1_swapped.cmd = s1_data.cmd;
    assign s1_swapped.ax  = s1_data.bx;
    assign s1_swapped.ay  = s1_data.by;
    assign s1_swapped.bx  = s1_data.ax;
    assign s1_swapped.by  = s1_data.ay;
    assign s1_swapped.w   = s1_data.w;
    assign s1_swapped.h   = s1_data.h;

    crbg_clip u_clip_src (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .o_ready (s2_ready),
        .i_data  (s1_swapped),
        .i_lim_x (dims.src_w),
        .i_lim_y (dims.src_h),
        .o_valid (s2_valid),
        .i_ready (row_ready),
        .o_data  (s2_data)
    );

    crbg_row u_row (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s2_valid),
        .o_ready     (row_ready),
        .i_data      (s2_data),
        .i_cfg       (cfg),
        .i_dims      (dims),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

[tb/sv/clipped_blit_row_checker.sv]
`default_nettype none

module clipped_blit_row_checker
    import crbg_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    input  wire logic                  i_in_stall,
    input  wire t_in_item              i_in,
    input  wire logic                  i_out_valid,
    input  wire logic                  i_out_stall,
    input  wire t_out_item             i_out,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                         o_fail_count,
    output int                         o_rows_due
);
    timeunit 1ns;
    timeprecision 1ps;

    t_cfg              regs;
    logic              blit_busy;
    logic [OFF_W-1:0]  dst_row_base;
    logic [OFF_W-1:0]  src_row_base;
    logic [DIM_W-1:0]  rows_left;
    logic [DIM_W-1:0]  row_pixels;
    logic              swap_pixels;
    logic [DIM_W-1:0]  dst_pitch;
    logic [DIM_W-1:0]  src_pitch;
    t_out_item         rows_due[$];
    int                beat_count;

    task automatic report_fault(input string msg);
        $display("ERROR: beat %0d: %s", beat_count, msg);
        o_fail_count++;
    endtask

    function automatic longint pitch_of(input t_dim v);
        return (v > MAX_DIM) ? longint'(MAX_DIM) : longint'(v);
    endfunction

    function automatic t_out_item predict_beat(input t_in_item c);
        t_out_item r;
        longint    dx, dy, sx, sy, w, h, dw, dh, sw, sh, cut;
        r = '0;
        if (c.cmd == CMD_START) begin
            dx = longint'($signed(c.dst_x));
            dy = longint'($signed(c.dst_y));
            sx = longint'($signed(c.src_x));
            sy = longint'($signed(c.src_y));
            w  = longint'(c.rect_width);
            h  = longint'(c.rect_height);
            dw = pitch_of(regs.dst_width);
            dh = pitch_of(regs.dst_height);
            sw = pitch_of(regs.src_width);
            sh = pitch_of(regs.src_height);
            if (dx < 0) begin
                cut = -dx; dx += cut; sx += cut; w -= cut;
            end
            if (dy < 0) begin
                cut = -dy; dy += cut; sy += cut; h -= cut;
            end
            if (dx + w > dw) w -= (dx + w) - dw;
            if (dy + h > dh) h -= (dy + h) - dh;
            if (sx < 0) begin
                cut = -sx; dx += cut; sx += cut; w -= cut;
            end
            if (sy < 0) begin
                cut = -sy; dy += cut; sy += cut; h -= cut;
            end
            if (sx + w > sw) w -= (sx + w) - sw;
            if (sy + h > sh) h -= (sy + h) - sh;
            if (w <= 0 || h <= 0 || regs.dst_pixel_bytes != PIXEL_BYTES ||
                regs.src_pixel_bytes != PIXEL_BYTES) begin
                blit_busy    = 1'b0;
                rows_left    = '0;
                row_pixels   = '0;
                r.copy_empty = 1'b1;
            end else begin
                blit_busy    = 1'b1;
                dst_pitch    = DIM_W'(dw);
                src_pitch    = DIM_W'(sw);
                dst_row_base = OFF_W'(dy * dw + dx);
                src_row_base = OFF_W'(sy * sw + sx);
                rows_left    = DIM_W'(h);
                row_pixels   = DIM_W'(w);
                swap_pixels  = regs.dst_big_endian != regs.src_big_endian;
            end
        end else if (blit_busy && rows_left != 0) begin
            r.row_valid   = 1'b1;
            r.dst_offset  = dst_row_base;
            r.src_offset  = src_row_base;
            r.pixel_count = row_pixels;
            r.swap_bytes  = swap_pixels;
            r.last_row    = rows_left == 1;
            rows_left     = rows_left - 1'b1;
            dst_row_base  = dst_row_base + OFF_W'(dst_pitch);
            src_row_base  = src_row_base + OFF_W'(src_pitch);
            if (rows_left == 0) blit_busy = 1'b0;
        end
        return r;
    endfunction

    task automatic check_row(input t_out_item got);
        t_out_item want;
        if (rows_due.size() == 0) begin
            report_fault("result beat with nothing expected");
            return;
        end
        want = rows_due.pop_front();
        if (got.row_valid !== want.row_valid)
            report_fault($sformatf("row_valid %0b, want %0b", got.row_valid, want.row_valid));
        if (got.dst_offset !== want.dst_offset)
            report_fault($sformatf("dst_offset %0d, want %0d", got.dst_offset, want.dst_offset));
        if (got.src_offset !== want.src_offset)
            report_fault($sformatf("src_offset %0d, want %0d", got.src_offset, want.src_offset));
        if (got.pixel_count !== want.pixel_count)
            report_fault($sformatf("pixel_count %0d, want %0d",
                                   got.pixel_count, want.pixel_count));
        if (got.swap_bytes !== want.swap_bytes)
            report_fault($sformatf("swap_bytes %0b, want %0b", got.swap_bytes, want.swap_bytes));
        if (got.last_row !== want.last_row)
            report_fault($sformatf("last_row %0b, want %0b", got.last_row, want.last_row));
        if (got.copy_empty !== want.copy_empty)
            report_fault($sformatf("copy_empty %0b, want %0b", got.copy_empty, want.copy_empty));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            regs.dst_width       = 11'd320;
            regs.dst_height      = 11'd240;
            regs.src_width       = 11'd320;
            regs.src_height      = 11'd240;
            regs.dst_pixel_bytes = PIXEL_BYTES;
            regs.src_pixel_bytes = PIXEL_BYTES;
            regs.dst_big_endian  = 1'b0;
            regs.src_big_endian  = 1'b0;
            blit_busy    = 1'b0;
            dst_row_base = '0;
            src_row_base = '0;
            rows_left    = '0;
            row_pixels   = '0;
            swap_pixels  = 1'b0;
            dst_pitch    = '0;
            src_pitch    = '0;
            rows_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                check_row(i_out);
                beat_count++;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_DST_WIDTH:       regs.dst_width = i_cfg_data;
                    CFG_DST_HEIGHT:      regs.dst_height = i_cfg_data;
                    CFG_SRC_WIDTH:       regs.src_width = i_cfg_data;
                    CFG_SRC_HEIGHT:      regs.src_height = i_cfg_data;
                    CFG_DST_PIXEL_BYTES: regs.dst_pixel_bytes = i_cfg_data[BPP_W-1:0];
                    CFG_SRC_PIXEL_BYTES: regs.src_pixel_bytes = i_cfg_data[BPP_W-1:0];
                    CFG_DST_BIG_ENDIAN:  regs.dst_big_endian = i_cfg_data[0];
                    CFG_SRC_BIG_ENDIAN:  regs.src_big_endian = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) rows_due.push_back(predict_beat(i_in));
        end
        o_rows_due = rows_due.size();
    end

endmodule

`default_nettype wire

[tb/sv/clipped_blit_row_generator_tb.sv]
`default_nettype none

module clipped_blit_row_generator_tb
    import crbg_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 300;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    t_in_item              in_beat = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out_item             out_beat;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    int                    fail_count;
    int                    rows_due;
    int                    burst_left = 0;
    int                    cycle_count = 0;
    int                    span_dx = 320;
    int                    span_dy = 240;
    int                    span_sx = 320;
    int                    span_sy = 240;

    clipped_blit_row_generator dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_beat),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    clipped_blit_row_checker checker_inst (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in         (in_beat),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out        (out_beat),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_rows_due   (rows_due)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("clipped_blit_row_generator_tb NOT OK");
        $finish;
    end

    initial begin
        int seg_len;
        int mode;
        int seg_count;
        seg_count = 0;
        forever begin
            seg_count++;
            if (seg_count == 6 || $urandom_range(0, 7) == 0) begin
                for (int k = 0; k < LONG_HOLD; k++) begin
                    @(negedge clk);
                    out_stall <= 1'b1;
                end
            end else begin
                seg_len = $urandom_range(20, 100);
                mode = $urandom_range(0, 3);
                for (int k = 0; k < seg_len; k++) begin
                    @(negedge clk);
                    case (mode)
                        0: out_stall <= 1'b0;
                        1: out_stall <= ($urandom_range(0, 3) == 0);
                        2: out_stall <= ($urandom_range(0, 9) < 6);
                        default: out_stall <= (k % 3 == 0);
                    endcase
                end
            end
        end
    end

    // call at a falling edge; returns at the falling edge after the beat is taken
    task automatic send_beat(input t_in_item beat);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        in_valid <= 1'b1;
        in_beat  <= beat;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        burst_left--;
    endtask

    task automatic send_start(input int dx, input int dy, input int sx, input int sy,
                              input int w, input int h);
        t_in_item beat;
        beat.cmd         = CMD_START;
        beat.dst_x       = 16'(dx);
        beat.dst_y       = 16'(dy);
        beat.src_x       = 16'(sx);
        beat.src_y       = 16'(sy);
        beat.rect_width  = 15'(w);
        beat.rect_height = 15'(h);
        send_beat(beat);
    endtask

    task automatic send_next();
        t_in_item beat;
        beat.cmd         = CMD_NEXT;
        beat.dst_x       = 16'($urandom);
        beat.dst_y       = 16'($urandom);
        beat.src_x       = 16'($urandom);
        beat.src_y       = 16'($urandom);
        beat.rect_width  = 15'($urandom);
        beat.rect_height = 15'($urandom);
        send_beat(beat);
    endtask

    task automatic send_noise();
        t_in_item beat;
        beat.cmd         = ($urandom_range(0, 1) == 0) ? CMD_START : CMD_NEXT;
        beat.dst_x       = 16'($urandom);
        beat.dst_y       = 16'($urandom);
        beat.src_x       = 16'($urandom);
        beat.src_y       = 16'($urandom);
        beat.rect_width  = 15'($urandom);
        beat.rect_height = 15'($urandom);
        send_beat(beat);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        burst_left = 0;
        while (rows_due != 0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input int value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        @(negedge clk);
    endtask

    function automatic int span_of(input int v);
        if (v > MAX_DIM) return MAX_DIM;
        if (v < 1) return 1;
        return v;
    endfunction

    task automatic set_phase(input int dw, input int dh, input int sw, input int sh,
                             input int dpb, input int spb, input int dbe, input int sbe);
        drain();
        write_reg(CFG_DST_WIDTH, dw);
        write_reg(CFG_DST_HEIGHT, dh);
        write_reg(CFG_SRC_WIDTH, sw);
        write_reg(CFG_SRC_HEIGHT, sh);
        write_reg(CFG_DST_PIXEL_BYTES, dpb);
        write_reg(CFG_SRC_PIXEL_BYTES, spb);
        write_reg(CFG_DST_BIG_ENDIAN, dbe);
        write_reg(CFG_SRC_BIG_ENDIAN, sbe);
        cfg_we <= 1'b0;
        span_dx = span_of(dw);
        span_dy = span_of(dh);
        span_sx = span_of(sw);
        span_sy = span_of(sh);
    endtask

    function automatic int near_pos(input int span);
        case ($urandom_range(0, 9))
            0: return int'($urandom_range(0, 65535)) - 32768;
            1: return -int'($urandom_range(1, 16));
            default: return int'($urandom_range(0, span + 4)) - 2;
        endcase
    endfunction

    task automatic run_blits(input int n_items);
        int sent;
        int w;
        int h;
        int rows;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 4) == 0) begin
                send_noise();
                sent++;
            end else begin
                w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 32767) : $urandom_range(1, 40);
                h = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 32) : $urandom_range(1, 6);
                send_start(near_pos(span_dx), near_pos(span_dy), near_pos(span_sx),
                           near_pos(span_sy), w, h);
                rows = h;
                case ($urandom_range(0, 9))
                    0: rows = $urandom_range(0, h);
                    1: rows = h + 2;
                    default: ;
                endcase
                repeat (rows) send_next();
                sent += rows + 1;
            end
        end
    endtask

    initial begin
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        send_next();
        send_start(10, 5, 0, 0, 4, 2);
        repeat (3) send_next();
        send_start(-3, -2, 5, 5, 8, 4);
        repeat (2) send_next();
        send_start(-32768, -32768, 0, 0, 32767, 32767);
        send_start(32767, 32767, 0, 0, 32767, 32767);
        send_start(0, 0, -32768, 0, 32767, 3);
        send_start(300, 230, 310, 0, 32767, 32767);
        repeat (2) send_next();
        send_start(0, 0, 319, 239, 1, 1);
        send_next();
        send_start(5, 5, 5, 5, 0, 7);
        send_start(5, 5, 5, 5, 7, 0);
        send_next();

        set_phase(320, 240, 320, 240, 2, 2, 0, 1);
        run_blits(85);
        set_phase(1, 1, 1, 1, 2, 2, 1, 0);
        run_blits(60);
        set_phase(1024, 1024, 1024, 1024, 2, 2, 1, 1);
        run_blits(85);
        set_phase(2047, 1025, 1500, 2047, 2, 2, 0, 1);
        run_blits(85);
        set_phase(0, 240, 320, 0, 2, 2, 0, 0);
        run_blits(40);
        set_phase(64, 48, 100, 30, 3, 2, 1, 0);
        run_blits(40);
        set_phase(40, 30, 50, 20, 2, 7, 0, 1);
        run_blits(40);
        set_phase(64, 64, 64, 64, 0, 2, 1, 1);
        run_blits(30);
        for (int p = 0; p < 5; p++) begin
            set_phase($urandom_range(1, 200), $urandom_range(1, 200),
                      $urandom_range(1, 200), $urandom_range(1, 200),
                      ($urandom_range(0, 4) == 0) ? $urandom_range(0, 7) : 2,
                      ($urandom_range(0, 4) == 0) ? $urandom_range(0, 7) : 2,
                      $urandom_range(0, 1), $urandom_range(0, 1));
            run_blits(85);
        end

        in_valid <= 1'b0;
        while (rows_due != 0) @(negedge clk);
        repeat (16) @(negedge clk);
        if (fail_count == 0 && rows_due == 0) begin
            $display("clipped_blit_row_generator_tb OK");
        end else begin
            $display("clipped_blit_row_generator_tb NOT OK");
        end
        $finish;
    end

endmodule

`default_nettype wire
